// ----- hw/rtl/efsa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efsa_pkg
// Shared constants and types for the earliest-free-server assigner.
// ----------------------------------------------------------------------------
package efsa_pkg;

  localparam int SERVERS    = 16;
  localparam int TIME_WIDTH = 32;

  // fixed port widths
  localparam int DUR_W = 16;
  localparam int AMT_W = 16;
  localparam int VAL_W = 32;   // time and total fields
  localparam int CFG_W = 5;
  localparam int SRV_W = 4;    // server field

  localparam int IDX_W = (SERVERS > 1) ? $clog2(SERVERS) : 1;
  localparam int CNT_W = 5;    // job counter, saturates at 31

  localparam logic [VAL_W-1:0] TIME_MAX = (TIME_WIDTH >= VAL_W) ? {VAL_W{1'b1}} :
                                          VAL_W'((64'd1 << TIME_WIDTH) - 64'd1);
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(SERVERS);
  localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};

  localparam logic KIND_ASSIGN  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_UPDATE = 5'b00100,
    S_MAX    = 5'b01000,
    S_SUM    = 5'b10000
  } state_t;

endpackage

// ----- hw/rtl/earliest_free_server_assigner_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// earliest_free_server_assigner_top
// Hands jobs to the server that frees up soonest and reports per-server totals.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one job: duration, amount,
//   last_job. in_stall is low only while the sequencer is idle.
//   Output channel (out_valid / out_stall) carries results from a single
//   output register; the block takes the next job while a result still waits.
//   Config channel (cfg_valid / cfg_ready, num_servers) is taken when idle.
// Sequence per job, n = servers in use:
//   First n jobs of a batch: accept, then update.
//   Later jobs: one comparator walks the free times of servers 1..n-1,
//   one per cycle, then an update writes back. A job with last_job adds
//   a makespan pass over all SERVERS free times through the same comparator,
//   then n summary items, one per cycle while out_stall holds no result.
// Reset (rst, synchronous): all free times and totals clear, num_servers
//   returns to 16, no result is valid. Batch end clears free times and totals.
// Stall: while out_stall holds a result, the next update or summary waits,
//   and nothing is lost or repeated.
// ----------------------------------------------------------------------------
module earliest_free_server_assigner_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [efsa_pkg::CFG_W-1:0]  num_servers,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [efsa_pkg::DUR_W-1:0]  duration,
  input  logic [efsa_pkg::AMT_W-1:0]  amount,
  input  logic                        last_job,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        kind,
  output logic [efsa_pkg::SRV_W-1:0]  server,
  output logic [efsa_pkg::VAL_W-1:0]  time_value,
  output logic [efsa_pkg::VAL_W-1:0]  finish_time,
  output logic [efsa_pkg::VAL_W-1:0]  amount_sum,
  output logic                        saturated,
  output logic                        last
);
  import efsa_pkg::*;

  state_t             state;
  logic [CFG_W-1:0]   servers_cfg;
  logic [VAL_W-1:0]   free_time    [SERVERS];
  logic [VAL_W-1:0]   amount_total [SERVERS];
  logic [CNT_W-1:0]   jobs_seen;
  logic               overflow_seen;

  logic [DUR_W-1:0]   dur_q;
  logic [AMT_W-1:0]   amt_q;
  logic               last_q;
  logic [CFG_W-1:0]   n_lat;
  logic [IDX_W-1:0]   idx;
  logic [IDX_W-1:0]   sel;
  logic [VAL_W-1:0]   best;

  logic [CFG_W-1:0]   n_eff;
  logic [IDX_W-1:0]   rd_addr;
  logic [VAL_W-1:0]   rd_time;
  logic [VAL_W-1:0]   rd_amt;
  logic [VAL_W-1:0]   cmp_a;
  logic [VAL_W-1:0]   cmp_b;
  logic               cmp_lt;
  logic               slot_free;
  logic [VAL_W:0]     fin_full;
  logic               fin_ovf;
  logic [VAL_W-1:0]   fin_val;
  logic [VAL_W:0]     sum_full;
  logic               sum_ovf;
  logic [VAL_W-1:0]   sum_val;
  logic               ov_next;
  logic               scan_end;
  logic               sum_last;
  logic               do_update;
  logic               do_summary;
  logic               batch_clear;
  logic               in_fire;
  logic               warm;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;

  always_comb begin
    n_eff = servers_cfg;
    if (servers_cfg == '0) begin
      n_eff = CFG_W'(1);
    end else if (servers_cfg > CFG_W'(SERVERS)) begin
      n_eff = CFG_W'(SERVERS);
    end
  end

  // first n jobs of a batch go to servers in order
  assign warm = (n_eff <= jobs_seen);

  // single read port on the state arrays
  always_comb begin
    case (state)
      S_SCAN, S_MAX, S_SUM: rd_addr = idx;
      S_UPDATE:             rd_addr = sel;
      default:              rd_addr = '0;
    endcase
  end
  assign rd_time = free_time[rd_addr];
  assign rd_amt  = amount_total[rd_addr];

  // shared comparator: min search during SCAN, max search during MAX
  always_comb begin
    if (state == S_MAX) begin
      cmp_a = best;
      cmp_b = rd_time;
    end else begin
      cmp_a = rd_time;
      cmp_b = best;
    end
  end
  assign cmp_lt = (cmp_a < cmp_b);

  assign fin_full = {1'b0, rd_time} + (VAL_W+1)'(dur_q);
  assign fin_ovf  = (fin_full > {1'b0, TIME_MAX});
  assign fin_val  = fin_ovf ? TIME_MAX : fin_full[VAL_W-1:0];
  assign sum_full = {1'b0, rd_amt} + (VAL_W+1)'(amt_q);
  assign sum_ovf  = sum_full[VAL_W];
  assign sum_val  = sum_ovf ? {VAL_W{1'b1}} : sum_full[VAL_W-1:0];
  assign ov_next  = overflow_seen || fin_ovf || sum_ovf;

  assign scan_end    = (CFG_W'(idx) == n_lat - CFG_W'(1));
  assign sum_last    = scan_end;
  assign do_update   = (state == S_UPDATE) && slot_free;
  assign do_summary  = (state == S_SUM) && slot_free;
  assign batch_clear = do_summary && sum_last;

  // control and state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      servers_cfg   <= CFG_RESET;
      jobs_seen     <= '0;
      overflow_seen <= 1'b0;
      out_valid     <= 1'b0;
      for (int i = 0; i < SERVERS; i++) begin
        free_time[i]    <= '0;
        amount_total[i] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        servers_cfg <= num_servers;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (!warm) begin
              state <= S_UPDATE;
            end else if (n_eff == CFG_W'(1)) begin
              state <= S_UPDATE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (scan_end) begin
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          if (do_update) begin
            free_time[sel]    <= fin_val;
            amount_total[sel] <= sum_val;
            overflow_seen     <= ov_next;
            if (jobs_seen != CNT_MAX) begin
              jobs_seen <= jobs_seen + CNT_W'(1);
            end
            out_valid <= 1'b1;
            state     <= last_q ? S_MAX : S_IDLE;
          end
        end
        S_MAX: begin
          if (idx == IDX_W'(SERVERS - 1)) begin
            state <= S_SUM;
          end
        end
        S_SUM: begin
          if (do_summary) begin
            out_valid <= 1'b1;
            if (sum_last) begin
              state         <= S_IDLE;
              jobs_seen     <= '0;
              overflow_seen <= 1'b0;
              for (int i = 0; i < SERVERS; i++) begin
                free_time[i]    <= '0;
                amount_total[i] <= '0;
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // job registers and sequencer datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          dur_q  <= duration;
          amt_q  <= amount;
          last_q <= last_job;
          n_lat  <= n_eff;
          idx    <= IDX_W'(1);
          best   <= rd_time;   // free time of server 0
          sel    <= warm ? '0 : jobs_seen[IDX_W-1:0];
        end
      end
      S_SCAN: begin
        if (cmp_lt) begin
          best <= rd_time;
          sel  <= idx;
        end
        idx <= idx + IDX_W'(1);
      end
      S_UPDATE: begin
        idx  <= '0;
        best <= '0;
      end
      S_MAX: begin
        if (cmp_lt) begin
          best <= rd_time;
        end
        idx <= (idx == IDX_W'(SERVERS - 1)) ? '0 : idx + IDX_W'(1);
      end
      S_SUM: begin
        if (do_summary) begin
          idx <= idx + IDX_W'(1);
        end
      end
      default: begin
        idx <= '0;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (do_update) begin
      kind        <= KIND_ASSIGN;
      server      <= SRV_W'(sel);
      time_value  <= rd_time;
      finish_time <= fin_val;
      amount_sum  <= sum_val;
      saturated   <= ov_next;
      last        <= !last_q;
    end else if (do_summary) begin
      kind        <= KIND_SUMMARY;
      server      <= SRV_W'(idx);
      time_value  <= best;
      finish_time <= '0;
      amount_sum  <= rd_amt;
      saturated   <= overflow_seen;
      last        <= sum_last;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_sel_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPDATE) |-> (CFG_W'(sel) < n_lat))
    else $error("selected server outside servers in use");

  a_finish_after_start: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_ASSIGN) |-> (finish_time >= time_value))
    else $error("assignment finishes before it starts");

  a_batch_clears: assert property (@(posedge clk) disable iff (rst)
    batch_clear |=> (jobs_seen == '0) && !overflow_seen && (state == S_IDLE))
    else $error("batch end did not clear state");

  a_overflow_sticky: assert property (@(posedge clk) disable iff (rst)
    (overflow_seen && !batch_clear) |=> overflow_seen)
    else $error("overflow flag dropped inside a batch");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(time_value) && $stable(server))
    else $error("pending result overwritten");

endmodule
